// File: sv/mtrb_pkg.sv
package mtrb_pkg;

  localparam int DEPTH         = 16;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int PAY_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_PULL   = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_SWAP   = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_FULL     = 3'd1,
    RC_EMPTY    = 3'd2,
    RC_INACTIVE = 3'd3,
    RC_BADPOS   = 3'd4,
    RC_NOSPACE  = 3'd5
  } rc_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_REMOVED = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_PUT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_W,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

// File: sv/mtrb_ram.sv
module mtrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/max_tracking_record_buffer_top.sv
// Record buffer of 16 slots that tracks the largest active key (signed compare, lowest slot wins
// ties). Keys and payloads live in one RAM with a registered read; slot status, count and the
// maximum index sit in flops. One command is taken at a time; s_axis_tready is high only while
// the block is idle. Every command that changes the slots ends with a scan of all 16 slots, one
// RAM read a cycle. An insert that shifts first moves the occupied slots one by one and then
// writes the new record; a swap reads both slots, then writes each back to the other. The
// result waits in an output register until m_axis_tready takes it.
module max_tracking_record_buffer_top #(
  parameter int KEY_WIDTH     = mtrb_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = mtrb_pkg::PAY_WIDTH_DEF,
  localparam int DATA_W = ((KEY_WIDTH + PAYLOAD_WIDTH + 10 + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // key_in, payload_in, status_in, index_a, index_b
  input  logic [DATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // key_out, payload_out, count_out, max_valid, max_slot
  output logic [DATA_W-1:0] m_axis_tdata,
  // result_code
  output logic [2:0]        m_axis_tuser
);

  import mtrb_pkg::*;

  localparam int RW = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int PW = PAYLOAD_WIDTH;
  localparam int KW = KEY_WIDTH;

  state_e state_q, state_d;

  logic [1:0]       status_q [DEPTH];
  logic [1:0]       status_d [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic             maxv_q, maxv_d;
  logic [IDX_W-1:0] maxi_q, maxi_d;

  logic [2:0]       cmd_q, cmd_d;
  logic [KW-1:0]    key_q, key_d;
  logic [PW-1:0]    pay_q, pay_d;
  logic [IDX_W-1:0] ia_q, ia_d;
  logic [IDX_W-1:0] ib_q, ib_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic             up_q, up_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] wdst_q, wdst_d;
  logic [RW-1:0]    tmp_q, tmp_d;
  logic             sv_q, sv_d;
  logic [IDX_W-1:0] sidx_q, sidx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             found_q, found_d;
  logic [KW-1:0]    best_q, best_d;
  logic [IDX_W-1:0] bi_q, bi_d;
  logic [2:0]       rc_q, rc_d;
  logic [KW-1:0]    ko_q, ko_d;
  logic [PW-1:0]    po_q, po_d;

  logic              ov_q, ov_d;
  logic [2:0]        orc_q, orc_d;
  logic [DATA_W-1:0] odata_q, odata_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0]    ram_wdata, ram_rdata;

  logic [KW-1:0]    in_key;
  logic [PW-1:0]    in_pay;
  logic [1:0]       in_st;
  logic [IDX_W-1:0] in_ia, in_ib;
  logic [KW-1:0]    rd_key;
  logic [PW-1:0]    rd_pay;

  logic             up_ok, dn_ok;
  logic [IDX_W-1:0] fu, fd;

  assign in_key = s_axis_tdata[KW-1:0];
  assign in_pay = s_axis_tdata[RW-1:KW];
  assign in_st  = s_axis_tdata[RW+1:RW];
  assign in_ia  = s_axis_tdata[RW+5:RW+2];
  assign in_ib  = s_axis_tdata[RW+9:RW+6];
  assign rd_key = ram_rdata[RW-1:PW];
  assign rd_pay = ram_rdata[PW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = orc_q;

  mtrb_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // free slot search for an insert into an active slot
  always_comb begin
    up_ok = 1'b0;
    dn_ok = 1'b0;
    fu    = '0;
    fd    = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (j > int'(in_ia) && status_q[j] != ST_ACTIVE) begin
        up_ok = 1'b1;
        fu    = IDX_W'(j);
      end
    end
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (j < int'(in_ia) && status_q[j] != ST_ACTIVE) begin
        dn_ok = 1'b1;
        fd    = IDX_W'(j);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    count_d   = count_q;
    maxv_d    = maxv_q;
    maxi_d    = maxi_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    pay_d     = pay_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    tgt_d     = tgt_q;
    up_d      = up_q;
    ptr_d     = ptr_q;
    pend_d    = pend_q;
    wdst_d    = wdst_q;
    tmp_d     = tmp_q;
    sv_d      = sv_q;
    sidx_d    = sidx_q;
    n_d       = n_q;
    found_d   = found_q;
    best_d    = best_q;
    bi_d      = bi_q;
    rc_d      = rc_q;
    ko_d      = ko_q;
    po_d      = po_q;
    ov_d      = ov_q & ~m_axis_tready;
    orc_d     = orc_q;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {key_q, pay_q};
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tuser;
          key_d = in_key;
          pay_d = in_pay;
          ia_d  = in_ia;
          ib_d  = in_ib;
          rc_d  = RC_OK;
          ko_d  = '0;
          po_d  = '0;
          ptr_d = '0;
          sv_d  = 1'b0;
          n_d   = '0;
          found_d = 1'b0;
          state_d = S_DONE;
          unique case (cmd_e'(s_axis_tuser))
            CMD_APPEND: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                rc_d = RC_FULL;
              end else if (in_st != ST_ACTIVE) begin
                rc_d = RC_INACTIVE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IDX_W-1:0];
                ram_wdata = {in_key, in_pay};
                status_d[count_q[IDX_W-1:0]] = ST_ACTIVE;
                state_d   = S_SCAN;
              end
            end
            CMD_INSERT: begin
              if ({1'b0, in_ia} >= CNT_W'(DEPTH)) begin
                rc_d = RC_BADPOS;
              end else if (count_q >= CNT_W'(DEPTH)) begin
                rc_d = RC_FULL;
              end else if (in_st != ST_ACTIVE) begin
                rc_d = RC_INACTIVE;
              end else if (status_q[in_ia] != ST_ACTIVE) begin
                ram_we    = 1'b1;
                ram_waddr = in_ia;
                ram_wdata = {in_key, in_pay};
                status_d[in_ia] = ST_ACTIVE;
                state_d   = S_SCAN;
              end else if (up_ok) begin
                for (int j = 0; j < DEPTH; j++) begin
                  if (j > int'(in_ia) && j <= int'(fu)) begin
                    status_d[j] = status_q[(j + DEPTH - 1) % DEPTH];
                  end
                end
                status_d[in_ia] = ST_ACTIVE;
                up_d    = 1'b1;
                ptr_d   = {1'b0, fu};
                tgt_d   = in_ia;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end else if (dn_ok) begin
                for (int j = 0; j < DEPTH; j++) begin
                  if (j >= int'(fd) && j + 1 < int'(in_ia)) begin
                    status_d[j] = status_q[(j + 1) % DEPTH];
                  end
                end
                status_d[in_ia - 1'b1] = ST_ACTIVE;
                up_d    = 1'b0;
                ptr_d   = {1'b0, fd};
                tgt_d   = in_ia - 1'b1;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end else begin
                rc_d = RC_NOSPACE;
              end
            end
            CMD_PULL, CMD_PEEK: begin
              if (!maxv_q) begin
                rc_d = RC_EMPTY;
              end else begin
                ram_raddr = maxi_q;
                state_d   = S_RD_WAIT;
              end
            end
            CMD_READ: begin
              if ({1'b0, in_ia} >= CNT_W'(DEPTH)) begin
                rc_d = RC_BADPOS;
              end else if (count_q == '0) begin
                rc_d = RC_EMPTY;
              end else if (status_q[in_ia] != ST_ACTIVE) begin
                rc_d = RC_INACTIVE;
              end else begin
                ram_raddr = in_ia;
                state_d   = S_RD_WAIT;
              end
            end
            CMD_WRITE: begin
              if ({1'b0, in_ia} >= CNT_W'(DEPTH)) begin
                rc_d = RC_BADPOS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_ia;
                ram_wdata = {in_key, in_pay};
                status_d[in_ia] = (in_st == ST_UNUSED) ? ST_EMPTY : in_st;
                state_d   = S_SCAN;
              end
            end
            CMD_SWAP: begin
              if ({1'b0, in_ia} >= CNT_W'(DEPTH) || {1'b0, in_ib} >= CNT_W'(DEPTH)) begin
                rc_d = RC_BADPOS;
              end else if (count_q == '0) begin
                rc_d = RC_EMPTY;
              end else if (status_q[in_ia] != ST_ACTIVE || status_q[in_ib] != ST_ACTIVE) begin
                rc_d = RC_INACTIVE;
              end else begin
                ram_raddr = in_ia;
                state_d   = S_SWAP_A;
              end
            end
            CMD_CLEAR: begin
              for (int j = 0; j < DEPTH; j++) begin
                status_d[j] = ST_EMPTY;
              end
              state_d = S_SCAN;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_RD_WAIT: begin
        ko_d = rd_key;
        po_d = rd_pay;
        if (cmd_q == CMD_PULL) begin
          status_d[maxi_q] = ST_REMOVED;
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end

      // copy one slot a cycle: read the source, write it next cycle one slot toward the free slot
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wdst_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q[IDX_W-1:0] != tgt_q) begin
          ram_raddr = up_q ? ptr_q[IDX_W-1:0] - 1'b1 : ptr_q[IDX_W-1:0] + 1'b1;
          pend_d    = 1'b1;
          wdst_d    = ptr_q[IDX_W-1:0];
          ptr_d     = up_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_q;
        ptr_d     = '0;
        state_d   = S_SCAN;
      end

      S_SWAP_A: begin
        tmp_d     = ram_rdata;
        ram_raddr = ib_q;
        state_d   = S_SWAP_B;
      end

      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = ram_rdata;
        state_d   = S_SWAP_W;
      end

      S_SWAP_W: begin
        ram_we    = 1'b1;
        ram_waddr = ib_q;
        ram_wdata = tmp_q;
        ptr_d     = '0;
        state_d   = S_SCAN;
      end

      // recount and find the maximum, one slot read a cycle
      S_SCAN: begin
        if (ptr_q < CNT_W'(DEPTH)) begin
          ram_raddr = ptr_q[IDX_W-1:0];
          sv_d      = 1'b1;
          sidx_d    = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + 1'b1;
        end else begin
          sv_d = 1'b0;
        end
        if (sv_q) begin
          if (status_q[sidx_q] == ST_ACTIVE) begin
            n_d = n_q + 1'b1;
            if (!found_q || $signed(rd_key) > $signed(best_q)) begin
              found_d = 1'b1;
              best_d  = rd_key;
              bi_d    = sidx_q;
            end
          end
          if (sidx_q == IDX_W'(DEPTH - 1)) begin
            count_d = n_d;
            maxv_d  = found_d;
            maxi_d  = found_d ? bi_d : '0;
            sv_d    = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          orc_d   = rc_q;
          odata_d = DATA_W'({maxi_q, maxv_q, count_q, po_q, ko_q});
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int j = 0; j < DEPTH; j++) begin
        status_q[j] <= ST_EMPTY;
      end
      count_q <= '0;
      maxv_q  <= 1'b0;
      maxi_q  <= '0;
      pend_q  <= 1'b0;
      sv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      maxv_q   <= maxv_d;
      maxi_q   <= maxi_d;
      pend_q   <= pend_d;
      sv_q     <= sv_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    pay_q   <= pay_d;
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    tgt_q   <= tgt_d;
    up_q    <= up_d;
    ptr_q   <= ptr_d;
    wdst_q  <= wdst_d;
    tmp_q   <= tmp_d;
    sidx_q  <= sidx_d;
    n_q     <= n_d;
    found_q <= found_d;
    best_q  <= best_d;
    bi_q    <= bi_d;
    rc_q    <= rc_d;
    ko_q    <= ko_d;
    po_q    <= po_d;
    orc_q   <= orc_d;
    odata_q <= odata_d;
  end

endmodule
